FILE: sv/triangle_laplace_element_stiffness_top_defines.svh
// Assertion macros shared by the element stiffness RTL.
`ifndef TRIANGLE_LAPLACE_ELEMENT_STIFFNESS_TOP_DEFINES_SVH
`define TRIANGLE_LAPLACE_ELEMENT_STIFFNESS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLES_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLES_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tles_pkg.sv
// Types and constants shared by the element stiffness block.
package tles_pkg;

  localparam int NODE_BITS = 24;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;   // coordinate difference
  localparam int PROD_W    = 66;   // product of two differences
  localparam int DOT_W     = 67;   // sum or difference of two products
  localparam int KSUM_W    = 34;   // sum of three conductivities
  localparam int DEN_W     = 70;   // 6 * |twice area|
  localparam int ACC_W     = 101;  // |dot| * ksum
  localparam int QUOT_W    = 64;
  localparam int QCNT_W    = 2;    // queue fill count
  localparam int QDEPTH    = 2;

  typedef struct packed {
    logic [NODE_BITS-1:0] node_a;
    logic [NODE_BITS-1:0] node_b;
    logic [NODE_BITS-1:0] node_c;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] xb;
    logic signed [COORD_W-1:0] yb;
    logic signed [COORD_W-1:0] xc;
    logic signed [COORD_W-1:0] yc;
    logic [COORD_W-1:0] cond_a;
    logic [COORD_W-1:0] cond_b;
    logic [COORD_W-1:0] cond_c;
  } in_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] row_node;
    logic [NODE_BITS-1:0] col_node;
    logic signed [63:0]   entry_value;
    logic                 degenerate;
    logic                 last_entry;
  } out_t;

  // One classified element waiting for the back end.
  typedef struct packed {
    logic [2:0][NODE_BITS-1:0] node;
    logic [2:0][DIFF_W-1:0]    nx;
    logic [2:0][DIFF_W-1:0]    ny;
    logic [KSUM_W-1:0]         ksum;
    logic [DEN_W-1:0]          den;
    logic                      degen;
  } work_t;

endpackage

FILE: sv/triangle_laplace_element_stiffness_top.sv
// Top level of the P1 triangle Laplace element stiffness block.
//
//   channel | direction | payload          | handshake
//   --------+-----------+------------------+----------------------
//   in      | input     | tles_pkg::in_t   | in_valid / in_ready
//   out     | output    | tles_pkg::out_t  | out_valid / out_ready
//
// Each element yields nine beats, row a,b,c outer, column inner.
// A regular element runs each beat through dot product, scaling
// multiply, setup, bit-serial 64-step divider and output: the shared
// divider sets the pace. A degenerate element yields one beat per
// cycle while the output is not held. The front end runs three stages
// ahead and a two-entry queue lets it take new elements while the back
// end works. Reset (rst, synchronous) clears all valid state; no
// clearing pass. The output register accepts the next beat in the
// cycle the current one is taken.
module triangle_laplace_element_stiffness_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tles_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tles_pkg::out_t out_data
);

  // front to queue
  logic            push;
  tles_pkg::work_t push_data;
  logic            full;
  // queue to back
  logic            pop;
  logic            head_valid;
  tles_pkg::work_t head;

  tles_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  tles_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tles_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: sv/tles_front.sv
// Front end: takes elements, forms normals, area and conductivity sum.
module tles_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tles_pkg::in_t  in_data,
  output logic           push,
  output tles_pkg::work_t push_data,
  input  logic           full
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic [2:0][tles_pkg::NODE_BITS-1:0] node1, node2;
  logic [2:0][tles_pkg::DIFF_W-1:0]    nx1, ny1, nx2, ny2;
  logic [tles_pkg::KSUM_W-1:0]         ksum1, ksum2;
  logic signed [tles_pkg::PROD_W-1:0]  pa, pb;
  tles_pkg::work_t                     w3;

  logic signed [tles_pkg::DOT_W-1:0] dd;
  logic [tles_pkg::DOT_W-1:0]        ad;

  function automatic logic [tles_pkg::DIFF_W-1:0] dif(input logic [31:0] a, input logic [31:0] b);
    dif = {a[31], a} - {b[31], b};
  endfunction

  assign en3      = !v3 || !full;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign push     = v3 && !full;
  assign push_data = w3;

  assign dd = {pa[tles_pkg::PROD_W-1], pa} - {pb[tles_pkg::PROD_W-1], pb};
  assign ad = dd[tles_pkg::DOT_W-1] ? -dd : dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      node1 <= {in_data.node_c, in_data.node_b, in_data.node_a};
      nx1[0] <= dif(in_data.yb, in_data.yc);
      nx1[1] <= dif(in_data.yc, in_data.ya);
      nx1[2] <= dif(in_data.ya, in_data.yb);
      ny1[0] <= dif(in_data.xc, in_data.xb);
      ny1[1] <= dif(in_data.xa, in_data.xc);
      ny1[2] <= dif(in_data.xb, in_data.xa);
      ksum1 <= {2'b0, in_data.cond_a} + {2'b0, in_data.cond_b} + {2'b0, in_data.cond_c};
    end
    if (en2) begin
      node2 <= node1;
      nx2   <= nx1;
      ny2   <= ny1;
      ksum2 <= ksum1;
      // twice the signed area: ny2*nx1 - ny1*nx2
      pa <= $signed(ny1[2]) * $signed(nx1[1]);
      pb <= $signed(ny1[1]) * $signed(nx1[2]);
    end
    if (en3) begin
      w3.node  <= node2;
      w3.nx    <= nx2;
      w3.ny    <= ny2;
      w3.ksum  <= ksum2;
      w3.degen <= (dd == '0);
      w3.den   <= ({3'b0, ad} << 2) + ({3'b0, ad} << 1);
    end
  end

endmodule

FILE: sv/tles_queue.sv
// Two-entry queue between front and back ends.
module tles_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tles_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tles_pkg::work_t head
);

  tles_pkg::work_t            mem [tles_pkg::QDEPTH];
  logic                       wptr, rptr;
  logic [tles_pkg::QCNT_W-1:0] cnt;

  assign full       = (cnt == tles_pkg::QCNT_W'(tles_pkg::QDEPTH));
  assign head_valid = (cnt != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

FILE: sv/tles_back.sv
// Back end: per-entry dot product, scaling, serial divide, saturation.
`include "triangle_laplace_element_stiffness_top_defines.svh"
module tles_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  tles_pkg::work_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output tles_pkg::out_t  out_data
);

  localparam int SHIFT = 32 - FRAC_BITS;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DOT  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_PREP = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [1:0] j, k, midx;
  logic [5:0] cnt;
  logic signed [tles_pkg::PROD_W-1:0] p1, p2;
  logic [tles_pkg::DOT_W-1:0] adot;
  logic dneg, sat;
  logic [tles_pkg::ACC_W-1:0] acc, acc_next;
  logic [tles_pkg::DEN_W-1:0] rem;
  logic [63:0] nlo, quo;

  logic signed [tles_pkg::DOT_W-1:0] dot;
  logic [31:0] chunk;
  logic [65:0] prod;
  logic [127:0] num;
  logic [tles_pkg::DEN_W:0] trial, tdiff;
  logic ge, out_free, last;
  logic [63:0] val;

  assign dot = {p1[tles_pkg::PROD_W-1], p1} + {p2[tles_pkg::PROD_W-1], p2};
  assign prod = chunk * head.ksum;
  assign num = {27'b0, acc} << SHIFT;
  assign trial = {rem, nlo[63]};
  assign tdiff = trial - {1'b0, head.den};
  assign ge = (trial >= {1'b0, head.den});
  assign out_free = !out_valid || out_ready;
  assign last = (j == 2'd2) && (k == 2'd2);
  assign pop = (state == ST_OUT) && out_free && last;

  always_comb begin
    unique case (midx)
      2'd0:    chunk = adot[31:0];
      2'd1:    chunk = adot[63:32];
      default: chunk = {29'b0, adot[66:64]};
    endcase
    unique case (midx)
      2'd0:    acc_next = acc + {35'b0, prod};
      2'd1:    acc_next = acc + ({35'b0, prod} << 32);
      default: acc_next = acc + ({35'b0, prod} << 64);
    endcase
  end

  always_comb begin
    priority if (head.degen)  val = '0;
    else if (sat)             val = dneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else if (dneg)            val = (quo > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                                    : -quo;
    else                      val = quo[63] ? 64'h7FFF_FFFF_FFFF_FFFF : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      j <= '0;
      k <= '0;
    end else begin
      // hold until taken, reload when a new beat is written
      out_valid <= ((state == ST_OUT) && out_free) || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          j <= '0;
          k <= '0;
          if (head_valid) state <= head.degen ? ST_OUT : ST_DOT;
        end
        ST_DOT:  state <= ST_SUM;
        ST_SUM:  state <= ST_MUL;
        ST_MUL:  if (midx == 2'd2) state <= ST_PREP;
        ST_PREP: state <= ST_DIV;
        ST_DIV:  if (cnt == 6'd63) state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            if (last) state <= ST_IDLE;
            else begin
              if (k == 2'd2) begin
                k <= '0;
                j <= j + 1'b1;
              end else k <= k + 1'b1;
              state <= head.degen ? ST_OUT : ST_DOT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_DOT: begin
        p1 <= $signed(head.nx[j]) * $signed(head.nx[k]);
        p2 <= $signed(head.ny[j]) * $signed(head.ny[k]);
      end
      ST_SUM: begin
        dneg <= dot[tles_pkg::DOT_W-1];
        adot <= dot[tles_pkg::DOT_W-1] ? -dot : dot;
        acc  <= '0;
        midx <= '0;
      end
      ST_MUL: begin
        acc  <= acc_next;
        midx <= midx + 1'b1;
      end
      ST_PREP: begin
        sat <= ({6'b0, num[127:64]} >= head.den);
        // upper half is below the divisor when not saturated
        rem <= {6'b0, num[127:64]};
        nlo <= num[63:0];
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= ge ? tdiff[tles_pkg::DEN_W-1:0] : trial[tles_pkg::DEN_W-1:0];
        quo <= {quo[62:0], ge};
        nlo <= {nlo[62:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_data.row_node    <= head.node[j];
          out_data.col_node    <= head.node[k];
          out_data.entry_value <= val;
          out_data.degenerate  <= head.degen;
          out_data.last_entry  <= last;
        end
      end
      default: ;
    endcase
  end

  `TLES_IMPLY(a_div_not_degen, state == ST_DIV, !head.degen, "divider ran on degenerate element")
  `TLES_IMPLY(a_pop_last, pop, head_valid && j == 2'd2 && k == 2'd2, "pop before ninth entry")
  `TLES_IMPLY(a_degen_zero, out_valid && out_data.degenerate, out_data.entry_value == '0, "degenerate value not zero")
  `TLES_NEXT(a_pop_idle, pop, state == ST_IDLE, "back end not idle after pop")

endmodule

FILE: test/triangle_laplace_element_stiffness_checker.sv
// Checker for the element stiffness block: predicts the nine entries per element and compares.
module triangle_laplace_element_stiffness_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  tles_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  tles_pkg::out_t out_data,
  output int             pending,
  output int             fail_count
);

  tles_pkg::out_t entries_due[$];

  function automatic logic signed [127:0] sx(logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  // Nine entries, row outer, column inner; exact quotient truncated, then saturated.
  function automatic void predict_element(tles_pkg::in_t e);
    logic signed [127:0] xs[3];
    logic signed [127:0] ys[3];
    logic signed [127:0] nx[3];
    logic signed [127:0] ny[3];
    logic signed [127:0] area2;
    logic signed [127:0] dotv;
    logic [127:0] ksum;
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] quo;
    logic [tles_pkg::NODE_BITS-1:0] nd[3];
    logic degen;
    tles_pkg::out_t r;
    xs[0] = sx(e.xa); ys[0] = sx(e.ya);
    xs[1] = sx(e.xb); ys[1] = sx(e.yb);
    xs[2] = sx(e.xc); ys[2] = sx(e.yc);
    nd[0] = e.node_a; nd[1] = e.node_b; nd[2] = e.node_c;
    ksum = 128'(e.cond_a) + 128'(e.cond_b) + 128'(e.cond_c);
    area2 = (xs[1] - xs[0]) * (ys[2] - ys[0]) - (xs[2] - xs[0]) * (ys[1] - ys[0]);
    degen = (area2 == 0);
    den = (area2 < 0 ? -area2 : area2) * 6;
    for (int i = 0; i < 3; i++) begin
      nx[i] = ys[(i + 1) % 3] - ys[(i + 2) % 3];
      ny[i] = xs[(i + 2) % 3] - xs[(i + 1) % 3];
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        r.row_node = nd[j];
        r.col_node = nd[k];
        r.degenerate = degen;
        r.last_entry = (j == 2 && k == 2);
        r.entry_value = '0;
        if (!degen) begin
          dotv = nx[j] * nx[k] + ny[j] * ny[k];
          num = ((dotv < 0 ? -dotv : dotv) * ksum) << (32 - FRAC_BITS);
          quo = num / den;
          if (dotv < 0) begin
            if (quo > 128'h8000_0000_0000_0000) r.entry_value = 64'h8000_0000_0000_0000;
            else r.entry_value = -quo[63:0];
          end else begin
            if (quo > 128'h7FFF_FFFF_FFFF_FFFF) r.entry_value = 64'h7FFF_FFFF_FFFF_FFFF;
            else r.entry_value = quo[63:0];
          end
        end
        entries_due.insert(entries_due.size(), r);
      end
    end
  endfunction

  always @(posedge clk) begin
    tles_pkg::out_t want;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict_element(in_data);
      if (out_valid && out_ready) begin
        if (entries_due.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, out_data);
          fail_count++;
        end else begin
          want = entries_due.pop_front();
          if (want.row_node !== out_data.row_node) begin
            $display("%0t: row_node exp %h got %h", $time, want.row_node, out_data.row_node);
            fail_count++;
          end
          if (want.col_node !== out_data.col_node) begin
            $display("%0t: col_node exp %h got %h", $time, want.col_node, out_data.col_node);
            fail_count++;
          end
          if (want.entry_value !== out_data.entry_value) begin
            $display("%0t: entry_value exp %h got %h", $time, want.entry_value,
                     out_data.entry_value);
            fail_count++;
          end
          if (want.degenerate !== out_data.degenerate) begin
            $display("%0t: degenerate exp %b got %b", $time, want.degenerate,
                     out_data.degenerate);
            fail_count++;
          end
          if (want.last_entry !== out_data.last_entry) begin
            $display("%0t: last_entry exp %b got %b", $time, want.last_entry,
                     out_data.last_entry);
            fail_count++;
          end
        end
      end
    end
    pending = entries_due.size();
  end
endmodule

FILE: test/triangle_laplace_element_stiffness_top_test.sv
// Testbench top for the element stiffness block: stimulus, back pressure and verdict.
module triangle_laplace_element_stiffness_top_test;

  localparam int RANDOM_ELEMENTS = 460;
  localparam int IDLE_LIMIT      = 5000;  // exceeds the beat spacing and the long hold-off
  localparam int DRAIN_CYCLES    = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tles_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tles_pkg::out_t out_data;
  int   pending;
  int   fail_count;
  int   idle_cycles = 0;
  bit   long_stall_done = 1'b0;
  int   beats_taken = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_laplace_element_stiffness_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  triangle_laplace_element_stiffness_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .pending(pending), .fail_count(fail_count)
  );

  // Watchdog: any accepted beat on either side resets the idle count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("triangle_laplace_element_stiffness_top verification failed");
      $finish;
    end
  end

  // Coordinates: full range in a quarter of picks, else small to keep results in range.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
      2: return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 24'sh800000);
      default: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000) <<< 8;
    endcase
  endfunction

  function automatic logic [31:0] pick_cond();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return 32'h0001_0000;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic tles_pkg::in_t random_element();
    tles_pkg::in_t e;
    e.node_a = tles_pkg::NODE_BITS'($urandom);
    e.node_b = tles_pkg::NODE_BITS'($urandom);
    e.node_c = tles_pkg::NODE_BITS'($urandom);
    e.xa = pick_coord(); e.ya = pick_coord();
    e.xb = pick_coord(); e.yb = pick_coord();
    e.xc = pick_coord(); e.yc = pick_coord();
    e.cond_a = pick_cond(); e.cond_b = pick_cond(); e.cond_c = pick_cond();
    // Collinear vertices now and then: repeated vertex or points on one line.
    case ($urandom_range(0, 9))
      0: begin e.xc = e.xa; e.yc = e.ya; end
      1: begin e.xb = e.xa; e.yb = e.ya; e.xc = e.xa; e.yc = e.ya; end
      2: begin e.xc = e.xb; e.yc = e.yb; end
      3: begin
        e.xa = 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
        e.ya = e.xa; e.xb = e.xa + 32'h100; e.yb = e.xb;
        e.xc = e.xa - 32'h3_0000; e.yc = e.xc;
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic tles_pkg::in_t make_element(logic [31:0] xa, ya, xb, yb, xc, yc,
                                                 ka, kb, kc);
    tles_pkg::in_t e;
    e.node_a = tles_pkg::NODE_BITS'($urandom);
    e.node_b = tles_pkg::NODE_BITS'($urandom);
    e.node_c = tles_pkg::NODE_BITS'($urandom);
    e.xa = xa; e.ya = ya; e.xb = xb; e.yb = yb; e.xc = xc; e.yc = yc;
    e.cond_a = ka; e.cond_b = kb; e.cond_c = kc;
    return e;
  endfunction

  // Offer one element, hold it until accepted, then leave on a falling edge.
  task automatic send_element(tles_pkg::in_t e);
    repeat ($urandom_range(0, 10)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random hold-off per beat, one long hold-off to back the block up.
  initial begin
    int holdoff;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      holdoff = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) holdoff = 0;  // runs with no stall
      if (!long_stall_done && beats_taken == 40) begin
        holdoff = 400;
        long_stall_done = 1'b1;
      end
      repeat (holdoff) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_taken++;
      @(negedge clk);
    end
  end

  initial begin
    tles_pkg::in_t directed[$];
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unit right triangle, unit conductivity.
    directed.insert(directed.size(), make_element(0, 0, 32'h1_0000, 0, 0, 32'h1_0000,
                                    32'h1_0000, 32'h1_0000, 32'h1_0000));
    // Same triangle, clockwise order.
    directed.insert(directed.size(), make_element(0, 0, 0, 32'h1_0000, 32'h1_0000, 0,
                                    32'h1_0000, 32'h1_0000, 32'h1_0000));
    // Zero area: all three vertices equal, and collinear points.
    directed.insert(directed.size(), make_element(32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.insert(directed.size(), make_element(0, 0, 32'h1_0000, 32'h1_0000, 32'h2_0000,
                                    32'h2_0000, 32'h1_0000, 0, 0));
    // Extreme coordinates, max and zero conductivity.
    directed.insert(directed.size(), make_element(32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.insert(directed.size(), make_element(32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 0, 0, 0));
    // Very thin triangle with huge edges: saturates both ways.
    directed.insert(directed.size(), make_element(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.insert(directed.size(), make_element(32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFE,
                                    32'hFFFF_FFFF, 32'h8000_0000, 32'h1));
    // Smallest nonzero area, smallest conductivity.
    directed.insert(directed.size(), make_element(0, 0, 1, 0, 0, 1, 1, 0, 0));
    // Node number extremes.
    begin
      tles_pkg::in_t e;
      e = make_element(0, 0, 32'h3_0000, 0, 0, 32'h4_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000);
      e.node_a = '0; e.node_b = '1; e.node_c = 24'hA5A5A5;
      directed.insert(directed.size(), e);
      e.node_a = '1; e.node_b = '0; e.node_c = 24'h5A5A5A;
      directed.insert(directed.size(), e);
    end

    foreach (directed[i]) send_element(directed[i]);
    for (int n = 0; n < RANDOM_ELEMENTS; n++) send_element(random_element());
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    waited = 0;
    while (waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (fail_count == 0) $display("triangle_laplace_element_stiffness_top verification clean");
    else $display("triangle_laplace_element_stiffness_top verification failed");
    $finish;
  end
endmodule

FILE: triangle_laplace_element_stiffness_top.f
+incdir+sv
sv/tles_pkg.sv
sv/tles_front.sv
sv/tles_queue.sv
sv/tles_back.sv
sv/triangle_laplace_element_stiffness_top.sv
test/triangle_laplace_element_stiffness_checker.sv
test/triangle_laplace_element_stiffness_top_test.sv
